FILE: rtl/core/cfla_pkg.sv
// Shared types and codes for the chunked free-list block allocator.
// Holds the request/status codes, the controller state type and the
// command and status bundles between the controller and the datapath.
package cfla_pkg;

	// number of chunk slots; the 4-bit chunk fields on the ports fix it
	localparam int CHUNK_SLOTS = 16;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef enum logic [9:0] {
		S_IDLE       = 10'b00_0000_0001,
		S_DISPATCH   = 10'b00_0000_0010,
		S_SCAN       = 10'b00_0000_0100,
		S_PICK       = 10'b00_0000_1000,
		S_INIT       = 10'b00_0001_0000,
		S_CHUNK_RD   = 10'b00_0010_0000,
		S_ALLOC_LINK = 10'b00_0100_0000,
		S_ALLOC_DONE = 10'b00_1000_0000,
		S_FREE_UPD   = 10'b01_0000_0000,
		S_RESULT     = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic set_cur_in;
		logic set_cur_cache;
		logic scan_start;
		logic scan_step;
		logic pick_free;
		logic pick_idle;
		logic init_step;
		logic alloc_commit;
		logic free_commit;
		logic res_full;
		logic res_bad;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic req_free;
		logic free_ok;
		logic cache_hit;
		logic scan_last;
		logic found_free;
		logic found_idle;
		logic init_last;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/cfla_ctrl.sv
// Controller state machine of the block allocator.
// Sequences each request through the datapath; depends on cfla_pkg.
module cfla_ctrl import cfla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.req_free) begin
					if (sts.free_ok) begin
						cmd.set_cur_in = 1'b1;
						state_nx       = S_CHUNK_RD;
					end else begin
						cmd.res_bad = 1'b1;
						state_nx    = S_RESULT;
					end
				end else if (sts.cache_hit) begin
					cmd.set_cur_cache = 1'b1;
					state_nx          = S_CHUNK_RD;
				end else begin
					cmd.scan_start = 1'b1;
					state_nx       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_nx = S_PICK;
			end
			S_PICK: begin
				if (sts.found_free) begin
					cmd.pick_free = 1'b1;
					state_nx      = S_CHUNK_RD;
				end else if (sts.found_idle) begin
					cmd.pick_idle = 1'b1;
					state_nx      = S_INIT;
				end else begin
					cmd.res_full = 1'b1;
					state_nx     = S_RESULT;
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_last)
					state_nx = S_CHUNK_RD;
			end
			S_CHUNK_RD: begin
				state_nx = sts.req_free ? S_FREE_UPD : S_ALLOC_LINK;
			end
			S_ALLOC_LINK: begin
				state_nx = S_ALLOC_DONE;
			end
			S_ALLOC_DONE: begin
				cmd.alloc_commit = 1'b1;
				state_nx         = S_RESULT;
			end
			S_FREE_UPD: begin
				cmd.free_commit = 1'b1;
				state_nx        = S_RESULT;
			end
			S_RESULT: begin
				// hold until the output register can take the item
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: rtl/core/cfla_datapath.sv
// Datapath of the block allocator: link memory, per-chunk head/count memory,
// chunk flags, allocation cache, spare tracking and output register.
// Driven by cfla_ctrl through the cmd_t/sts_t bundles of cfla_pkg.
module cfla_datapath import cfla_pkg::*; #(
	parameter int MAX_BLOCKS  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_data,
	input  logic       req_type,
	input  logic [3:0] chunk_index,
	input  logic [7:0] block_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] granted_chunk,
	output logic [7:0] granted_block
);

	localparam int CW         = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
	localparam int BW         = $clog2(MAX_BLOCKS);
	localparam int LINK_DEPTH = CHUNK_SLOTS << BW;

	typedef logic [CW-1:0] cidx_t;

	// configuration
	logic [7:0] bc_q;
	logic [8:0] bc9;
	logic [8:0] n9;
	logic [7:0] n_eff;

	// latched request
	logic       req_free_q;
	cidx_t      cin_q;
	logic       cin_ok_q;
	logic [7:0] bidx_q;
	logic [8:0] ci9;

	// chunk bookkeeping
	cidx_t                  cur_q;
	logic [CHUNK_SLOTS-1:0] active_q;
	logic [CHUNK_SLOTS-1:0] nonempty_q;
	cidx_t                  cache_q;
	logic                   cache_vld_q;
	cidx_t                  spare_q;
	logic                   spare_vld_q;

	// search and init
	cidx_t      scan_q;
	logic       found_free_q;
	logic       found_idle_q;
	cidx_t      ffree_q;
	cidx_t      fidle_q;
	logic [7:0] init_q;

	// memories
	logic [15:0] chunk_mem [CHUNK_SLOTS];
	logic [15:0] chunk_rd_q;
	logic        chunk_we;
	logic [15:0] chunk_wdata;
	logic [7:0]  link_mem [LINK_DEPTH];
	logic [7:0]  link_rd_q;
	logic        link_we;
	logic [CW+BW-1:0] link_waddr;
	logic [CW+BW-1:0] link_raddr;
	logic [7:0]  link_wdata;

	// result
	logic [1:0] res_status_q;
	cidx_t      res_chunk_q;
	logic [7:0] res_block_q;
	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [3:0] out_chunk_q;
	logic [7:0] out_block_q;
	logic [8:0] res_chunk9;

	// derived
	logic [7:0] head_old;
	logic [7:0] cnt_old;
	logic       head_oob;
	logic [7:0] head_new;
	logic [7:0] cnt_dec;
	logic [7:0] cnt_inc;
	logic       goes_empty;
	logic       drop_spare;
	logic       cache_empty;

	assign bc9   = {1'b0, bc_q};
	assign n9    = (bc_q == 8'd0) ? 9'd1 :
	               ((bc9 > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : bc9);
	assign n_eff = n9[7:0];

	assign ci9 = 9'(chunk_index);

	assign head_old = chunk_rd_q[15:8];
	assign cnt_old  = chunk_rd_q[7:0];
	assign head_oob = ({1'b0, head_old} >= 9'(MAX_BLOCKS));
	assign head_new = head_oob ? 8'd0 : link_rd_q;
	assign cnt_dec  = cnt_old - 8'd1;
	assign cnt_inc  = (cnt_old == 8'hFF) ? cnt_old : cnt_old + 8'd1;

	assign goes_empty  = (cnt_inc == n_eff);
	assign drop_spare  = goes_empty && spare_vld_q && (spare_q != cur_q);
	// the freed chunk itself is never empty after the push
	assign cache_empty = (cache_q != cur_q) && !nonempty_q[cache_q];

	assign sts.req_free   = req_free_q;
	assign sts.free_ok    = cin_ok_q && active_q[cin_q] && (bidx_q < n_eff);
	assign sts.cache_hit  = cache_vld_q && active_q[cache_q] && nonempty_q[cache_q];
	assign sts.scan_last  = (scan_q == CW'(CHUNK_SLOTS - 1));
	assign sts.found_free = found_free_q;
	assign sts.found_idle = found_idle_q;
	assign sts.init_last  = (init_q == n_eff - 8'd1);
	assign sts.out_free   = !out_valid_q || out_ready;

	// memory port steering
	always_comb begin
		chunk_we    = 1'b0;
		chunk_wdata = {head_new, cnt_dec};
		link_we     = 1'b0;
		link_waddr  = {cur_q, init_q[BW-1:0]};
		link_wdata  = init_q + 8'd1;
		if (cmd.init_step && sts.init_last) begin
			chunk_we    = 1'b1;
			chunk_wdata = {8'd0, n_eff};
		end
		if (cmd.init_step)
			link_we = 1'b1;
		if (cmd.alloc_commit)
			chunk_we = 1'b1;
		if (cmd.free_commit) begin
			chunk_we    = 1'b1;
			chunk_wdata = {bidx_q, cnt_inc};
			link_we     = 1'b1;
			link_waddr  = {cur_q, bidx_q[BW-1:0]};
			link_wdata  = head_old;
		end
	end

	assign link_raddr = {cur_q, head_old[BW-1:0]};

	always_ff @(posedge clk) begin
		if (chunk_we)
			chunk_mem[cur_q] <= chunk_wdata;
		chunk_rd_q <= chunk_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_waddr] <= link_wdata;
		link_rd_q <= link_mem[link_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_free_q <= (req_type == REQ_FREE);
			cin_q      <= ci9[CW-1:0];
			cin_ok_q   <= (ci9 < 9'(CHUNK_SLOTS));
			bidx_q     <= block_index;
		end
		if (cmd.set_cur_in)
			cur_q <= cin_q;
		if (cmd.set_cur_cache)
			cur_q <= cache_q;
		if (cmd.pick_free)
			cur_q <= ffree_q;
		if (cmd.pick_idle)
			cur_q <= fidle_q;
		if (cmd.scan_step) begin
			if (!found_free_q && active_q[scan_q] && nonempty_q[scan_q])
				ffree_q <= scan_q;
			if (!found_idle_q && !active_q[scan_q])
				fidle_q <= scan_q;
		end
		if (cmd.res_bad) begin
			res_status_q <= ST_BAD;
			res_chunk_q  <= '0;
			res_block_q  <= 8'd0;
		end
		if (cmd.res_full) begin
			res_status_q <= ST_FULL;
			res_chunk_q  <= '0;
			res_block_q  <= 8'd0;
		end
		if (cmd.free_commit) begin
			res_status_q <= ST_OK;
			res_chunk_q  <= '0;
			res_block_q  <= 8'd0;
		end
		if (cmd.alloc_commit) begin
			res_status_q <= ST_OK;
			res_chunk_q  <= cur_q;
			res_block_q  <= head_old;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_chunk_q  <= res_chunk9[3:0];
			out_block_q  <= res_block_q;
		end
	end

	assign res_chunk9 = 9'(res_chunk_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q         <= 8'd255;
			active_q     <= '0;
			nonempty_q   <= '0;
			cache_q      <= '0;
			cache_vld_q  <= 1'b0;
			spare_q      <= '0;
			spare_vld_q  <= 1'b0;
			scan_q       <= '0;
			found_free_q <= 1'b0;
			found_idle_q <= 1'b0;
			init_q       <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				bc_q <= cfg_data;

			if (cmd.scan_start) begin
				scan_q       <= '0;
				found_free_q <= 1'b0;
				found_idle_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (!sts.scan_last)
					scan_q <= scan_q + CW'(1);
				if (active_q[scan_q] && nonempty_q[scan_q])
					found_free_q <= 1'b1;
				if (!active_q[scan_q])
					found_idle_q <= 1'b1;
			end

			if (cmd.pick_free) begin
				cache_q     <= ffree_q;
				cache_vld_q <= 1'b1;
			end
			if (cmd.pick_idle) begin
				cache_q     <= fidle_q;
				cache_vld_q <= 1'b1;
				init_q      <= 8'd0;
			end

			// lay out links i -> i+1, then mark the chunk live
			if (cmd.init_step) begin
				init_q <= init_q + 8'd1;
				if (sts.init_last) begin
					active_q[cur_q]   <= 1'b1;
					nonempty_q[cur_q] <= (n_eff != 8'd0);
				end
			end

			if (cmd.alloc_commit) begin
				nonempty_q[cur_q] <= (cnt_dec != 8'd0);
				if (spare_vld_q && (spare_q == cur_q))
					spare_vld_q <= 1'b0;
			end

			if (cmd.free_commit) begin
				nonempty_q[cur_q] <= (cnt_inc != 8'd0);
				if (drop_spare) begin
					active_q[spare_q]   <= 1'b0;
					nonempty_q[spare_q] <= 1'b0;
					if (!cache_vld_q || (cache_q == spare_q) || cache_empty) begin
						cache_q     <= cur_q;
						cache_vld_q <= 1'b1;
					end
				end
				if (goes_empty) begin
					spare_q     <= cur_q;
					spare_vld_q <= 1'b1;
				end
			end

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_chunk = out_chunk_q;
	assign granted_block = out_block_q;

endmodule

FILE: rtl/core/chunked_free_list_block_allocator.sv
// Top level of the chunked free-list block allocator.
// Joins cfla_ctrl and cfla_datapath; depends on cfla_pkg.
//
// Usage:
//   s_axis carries requests: tuser is the request kind (allocate or free),
//   tdata the chunk slot and block index of a block to free. m_axis returns
//   one item per request: tuser is the status (ok, pool full, bad free),
//   tdata the granted chunk slot and block on an allocate.
//   cfg_valid/cfg_data write the blocks-per-chunk register; it is always
//   ready and should only be written while no request is in flight.
// Sequencing (one request at a time, run by the controller):
//   free: DISPATCH, CHUNK_RD, FREE_UPD, RESULT; a bad free goes from
//   DISPATCH straight to RESULT. Allocate from the cached chunk: DISPATCH,
//   CHUNK_RD, ALLOC_LINK, ALLOC_DONE, RESULT. On a cache miss the chunk
//   scan visits one slot per cycle before PICK; activating an idle chunk
//   lays out its links, one per block, through the single link memory
//   write port. Pool full: the scan and PICK, then RESULT.
// Reset: all chunks idle, cache and spare cleared, block count 255; the
//   link memory needs no clearing. A stalled receiver holds the result in
//   the output register; the next request is still taken and waits in S_RESULT.
module chunked_free_list_block_allocator import cfla_pkg::*; #(
	parameter int MAX_BLOCKS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,       // block_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] chunk_index, [11:4] block_index, rest 0
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] granted_chunk, [11:4] granted_block, rest 0
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	cmd_t       cmd;
	sts_t       sts;
	logic [3:0] granted_chunk;
	logic [7:0] granted_block;

	assign cfg_ready = 1'b1;

	cfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfla_datapath #(
		.MAX_BLOCKS  (MAX_BLOCKS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.req_type      (s_axis_tuser),
		.chunk_index   (s_axis_tdata[3:0]),
		.block_index   (s_axis_tdata[11:4]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.status        (m_axis_tuser),
		.granted_chunk (granted_chunk),
		.granted_block (granted_block)
	);

	assign m_axis_tdata = {4'd0, granted_block, granted_chunk};

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the chunked free-list block allocator.
// Drives requests over the s_axis stream, predicts every result and checks m_axis.
// Depends on cfla_pkg and chunked_free_list_block_allocator.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cfla_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] chunk;
		logic [7:0] blk;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// allocator state as predicted
	bit [7:0] next_blk [16][256];
	bit       link_set [16][256];
	bit [7:0] head_blk [16];
	bit [7:0] free_cnt [16];
	bit       chunk_on [16];
	bit [3:0] cache_slot;
	bit       cache_ok;
	bit [3:0] spare_slot;
	bit       spare_ok;
	bit [7:0] blocks_cfg = 8'd255;

	grant_t      grant_fifo[$];
	logic [11:0] held_blocks[$];   // {chunk, block} granted and not yet freed
	grant_t      last_grant;
	int          err_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	chunked_free_list_block_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	function automatic int eff_blocks();
		return (blocks_cfg == 8'd0) ? 1 : int'(blocks_cfg);
	endfunction

	// Chunk an allocate would use; fresh marks an idle slot to activate.
	function automatic bit pick_chunk(output int c, output bit fresh);
		fresh = 1'b0;
		c = 0;
		if (cache_ok && chunk_on[cache_slot] && free_cnt[cache_slot] != 0) begin
			c = cache_slot;
			return 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (chunk_on[i] && free_cnt[i] != 0) begin
				c = i;
				return 1'b1;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (!chunk_on[i]) begin
				c = i;
				fresh = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic grant_t compute_grant(input logic rt, input logic [3:0] ci,
			input logic [7:0] bi);
		grant_t g;
		int c;
		int n;
		bit fresh;
		bit [3:0] old;
		g = '0;
		n = eff_blocks();
		if (rt == REQ_ALLOC) begin
			if (!pick_chunk(c, fresh)) begin
				g.status = ST_FULL;
				return g;
			end
			if (fresh) begin
				chunk_on[c] = 1'b1;
				for (int k = 0; k < n; k++) begin
					next_blk[c][k] = 8'(k + 1);
					link_set[c][k] = 1'b1;
				end
				head_blk[c] = '0;
				free_cnt[c] = 8'(n);
			end
			cache_slot = 4'(c);
			cache_ok = 1'b1;
			if (spare_ok && spare_slot == c)
				spare_ok = 1'b0;
			g.status = ST_OK;
			g.chunk = 4'(c);
			g.blk = head_blk[c];
			head_blk[c] = next_blk[c][g.blk];
			free_cnt[c] = free_cnt[c] - 8'd1;
		end else if (!chunk_on[ci] || bi >= n) begin
			g.status = ST_BAD;
		end else begin
			next_blk[ci][bi] = head_blk[ci];
			link_set[ci][bi] = 1'b1;
			head_blk[ci] = bi;
			if (free_cnt[ci] != 8'hFF)
				free_cnt[ci] = free_cnt[ci] + 8'd1;
			if (free_cnt[ci] == n) begin
				// keep one empty chunk: release the older spare
				if (spare_ok && spare_slot != ci) begin
					old = spare_slot;
					chunk_on[old] = 1'b0;
					head_blk[old] = '0;
					free_cnt[old] = '0;
					if (!cache_ok || cache_slot == old || free_cnt[cache_slot] == 0) begin
						cache_slot = ci;
						cache_ok = 1'b1;
					end
				end
				spare_slot = ci;
				spare_ok = 1'b1;
			end
			g.status = ST_OK;
		end
		return g;
	endfunction

	task automatic send_req(input logic rt, input logic [3:0] ci, input logic [7:0] bi);
		int gap;
		int c;
		bit fresh;
		logic [11:0] tag;
		// Never pop a link that was never written: push a block onto that chunk instead.
		if (rt == REQ_ALLOC && pick_chunk(c, fresh) && !fresh &&
				!link_set[c][head_blk[c]]) begin
			rt = REQ_FREE;
			ci = 4'(c);
			bi = 8'($urandom_range(eff_blocks() - 1));
		end
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= rt;
		s_axis_tdata <= {4'b0, bi, ci};
		do @(posedge clk); while (!s_axis_tready);
		last_grant = compute_grant(rt, ci, bi);
		grant_fifo = {grant_fifo, last_grant};
		if (rt == REQ_ALLOC && last_grant.status == ST_OK) begin
			tag = {last_grant.chunk, last_grant.blk};
			held_blocks = {held_blocks, tag};
		end
	endtask

	task automatic free_held();
		int idx;
		logic [11:0] e;
		idx = $urandom_range(held_blocks.size() - 1);
		e = held_blocks[idx];
		held_blocks.delete(idx);
		send_req(REQ_FREE, e[11:8], e[7:0]);
	endtask

	// Hold the sender until every result is back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (grant_fifo.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_blocks(input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blocks_cfg = v;
	endtask

	task automatic flag_error(input string what, input int want, input int got);
		err_count++;
		$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		grant_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grant_fifo.size() == 0) begin
				err_count++;
				$display("%0t ns: result with none pending: expected nothing, got status %0d",
					$time, m_axis_tuser);
			end else begin
				e = grant_fifo.pop_front();
				if (m_axis_tuser !== e.status)
					flag_error("status", e.status, m_axis_tuser);
				if (m_axis_tdata[3:0] !== e.chunk)
					flag_error("granted_chunk", e.chunk, m_axis_tdata[3:0]);
				if (m_axis_tdata[11:4] !== e.blk)
					flag_error("granted_block", e.blk, m_axis_tdata[11:4]);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Two-block chunks: activation, spare handling, bad frees, count change, double free.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_blocks(8'd2);
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_ALLOC, 4'hF, 8'hFF);
		send_req(REQ_ALLOC, 4'h5, 8'hA5);   // chunk 0 full: activate chunk 1
		send_req(REQ_FREE, 4'd0, 8'd1);
		send_req(REQ_FREE, 4'd0, 8'd0);     // chunk 0 empty, becomes spare
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_ALLOC, 4'h0, 8'h00);   // take from the spare
		send_req(REQ_FREE, 4'd1, 8'd0);
		send_req(REQ_FREE, 4'd1, 8'd1);
		send_req(REQ_FREE, 4'd0, 8'd0);     // second empty chunk: release chunk 1
		send_req(REQ_FREE, 4'd1, 8'd0);     // idle chunk
		send_req(REQ_FREE, 4'd0, 8'd2);     // block past count
		send_req(REQ_FREE, 4'd15, 8'd255);
		send_req(REQ_FREE, 4'd0, 8'd254);
		write_blocks(8'd3);
		send_req(REQ_FREE, 4'd0, 8'd2);     // spare fills up again, stays spare
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_FREE, 4'd0, 8'd1);
		send_req(REQ_FREE, 4'd0, 8'd1);     // double free
		send_req(REQ_ALLOC, 4'h0, 8'h00);
		send_req(REQ_ALLOC, 4'h0, 8'h00);
	endtask

	// One-block chunks: exhaust all slots, then give everything back.
	task automatic test_pool_full();
		int full_hits;
		int tries;
		full_hits = 0;
		tries = 0;
		write_blocks(8'd1);
		while (full_hits < 2 && tries < 200) begin
			send_req(REQ_ALLOC, 4'($urandom), 8'($urandom));
			if (last_grant.status == ST_FULL)
				full_hits++;
			tries++;
		end
		drain();   // sender waits for every outstanding result
		while (held_blocks.size() != 0)
			free_held();
	endtask

	task automatic test_random(input int count, input logic [7:0] bc, input int s_pct,
			input int r_pct, input bit pause_mid);
		int p_alloc;
		int r;
		p_alloc = 50;
		write_blocks(bc);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			// swing between filling and draining the pool
			if (i % 40 == 0)
				p_alloc = $urandom_range(20, 85);
			r = $urandom_range(99);
			if (r < 6)
				send_req(REQ_FREE, 4'($urandom), 8'($urandom));
			else if (held_blocks.size() != 0 && $urandom_range(99) >= p_alloc)
				free_held();
			else
				send_req(REQ_ALLOC, 4'($urandom), 8'($urandom));
			if (pause_mid && i == count / 2)
				drain();
		end
	endtask

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		err_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_random(250, 8'd3, 0, 0, 1'b1);
		test_random(150, 8'd255, 88, 0, 1'b0);
		test_random(300, 8'd5, 0, 88, 1'b0);
		test_random(250, 8'd1, 37, 37, 1'b0);
		test_random(300, 8'd8, 0, 0, 1'b1);
		test_random(150, 8'd128, 37, 37, 1'b0);
		test_random(200, 8'd2, 88, 0, 1'b0);
		drain();
		repeat (300) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/cfla_pkg.sv
rtl/core/cfla_ctrl.sv
rtl/core/cfla_datapath.sv
rtl/core/chunked_free_list_block_allocator.sv
bench/tb_top.sv
